FILE: rtl/ttds_pkg.sv
// ----------------------------------------------------------------------------
// Tick dispatch scheduler package
// Shared sizes, action and source codes, the result word and the control
// word of one alarm list cell.
// ----------------------------------------------------------------------------
package ttds_pkg;

  localparam int TASKS_PER_CLASS = 8;
  localparam int PERIODIC_MAX    = 8;
  localparam int ALARM_MAX       = 8;
  localparam int NUM_CLASSES     = 4;

  localparam int TW  = (TASKS_PER_CLASS > 1) ? $clog2(TASKS_PER_CLASS) : 1;
  localparam int CW  = $clog2(TASKS_PER_CLASS + 1);
  localparam int PW  = (PERIODIC_MAX > 1) ? $clog2(PERIODIC_MAX) : 1;
  localparam int PCW = $clog2(PERIODIC_MAX + 1);
  localparam int AW  = (ALARM_MAX > 1) ? $clog2(ALARM_MAX) : 1;
  localparam int ACW = $clog2(ALARM_MAX + 1);
  localparam int WW  = (CW > PCW) ? ((CW > ACW) ? CW : ACW) : ((PCW > ACW) ? PCW : ACW);

  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_ADD_RATE  = 3'd1;
  localparam logic [2:0] ACT_REM_RATE  = 3'd2;
  localparam logic [2:0] ACT_ADD_PER   = 3'd3;
  localparam logic [2:0] ACT_CLR_PER   = 3'd4;
  localparam logic [2:0] ACT_ADD_ALARM = 3'd5;

  localparam logic [2:0] SRC_1MS      = 3'd0;
  localparam logic [2:0] SRC_10MS     = 3'd1;
  localparam logic [2:0] SRC_100MS    = 3'd2;
  localparam logic [2:0] SRC_1S       = 3'd3;
  localparam logic [2:0] SRC_PERIODIC = 3'd4;
  localparam logic [2:0] SRC_ALARM    = 3'd5;

  localparam logic KIND_REPLY    = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [2:0] source;
    logic [7:0] fired_ref;
    logic [2:0] slot;
    logic       ok;
  } res_t;

  typedef struct packed {
    logic load;
    logic take;
    logic dec;
  } cell_ctl_t;

endpackage

FILE: rtl/ttds_alarm_cell.sv
// ----------------------------------------------------------------------------
// Alarm list cell
// Holds one alarm reference and its remaining ticks. It loads a new alarm,
// takes its right neighbor's contents when the list closes a gap, or counts
// down by one.
// ----------------------------------------------------------------------------
module ttds_alarm_cell (
  input  logic               clk,
  input  ttds_pkg::cell_ctl_t ctl,
  input  logic [7:0]         load_ref,
  input  logic [15:0]        load_cnt,
  input  logic [7:0]         next_ref,
  input  logic [15:0]        next_cnt,
  output logic [7:0]         ref_q,
  output logic [15:0]        cnt_q
);
  import ttds_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ref_q <= load_ref;
      cnt_q <= load_cnt;
    end else if (ctl.take) begin
      ref_q <= next_ref;
      cnt_q <= next_cnt;
    end else if (ctl.dec) begin
      cnt_q <= cnt_q - 16'd1;
    end
  end

endmodule

FILE: rtl/tick_task_dispatch_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Tick task dispatch scheduler
// Keeps rate-class task tables, periodic counters and a chain of alarm cells,
// and emits dispatch and reply words.
// ----------------------------------------------------------------------------
// Usage: an input word carries an action. Table actions (add or remove a rate
// task, add or clear periodics, add an alarm) give one reply word with last
// set, passed through the staging register to the output. A tick walks the
// 1 ms table, the three spreads, the periodic list and the alarm chain, one
// entry per cycle, emitting one dispatch word per fired entry; the final word
// carries last, and a tick that fires nothing gives no word. in_stall is
// high while an item is at work, so one item is handled at a time. Each
// word is held in a one-deep staging register before the output register,
// so that last can be set on the final word. When out_stall is high while
// out_valid is set, the walk pauses and the output word holds. Reset
// empties all lists and clears the tick counter; table contents are not
// cleared.
// ----------------------------------------------------------------------------
module tick_task_dispatch_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [1:0]  rate_class,
  input  logic [7:0]  task_ref,
  input  logic [2:0]  slot_index,
  input  logic [15:0] duration,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  source,
  output logic [7:0]  fired_ref,
  output logic [2:0]  slot,
  output logic        ok,
  output logic        last
);
  import ttds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_P1, S_SP1, S_SP2, S_SP3, S_PER, S_ALM, S_FLUSH
  } state_t;

  state_t state;

  logic [7:0]     rt [NUM_CLASSES][TASKS_PER_CLASS];
  logic [CW-1:0]  cnt [NUM_CLASSES];
  logic [CW-1:0]  spr [3];
  logic [9:0]     tc;
  logic [3:0]     c10;
  logic [6:0]     c100;

  logic [7:0]     p_ref [PERIODIC_MAX];
  logic [15:0]    p_rel [PERIODIC_MAX];
  logic [15:0]    p_rem [PERIODIC_MAX];
  logic [PCW-1:0] pcount;
  logic [ACW-1:0] acount;
  logic [WW-1:0]  i;

  logic [7:0]     a_ref [ALARM_MAX];
  logic [15:0]    a_cnt [ALARM_MAX];
  cell_ctl_t      a_ctl [ALARM_MAX];

  res_t h;
  logic h_v;
  res_t o;
  logic o_last;

  logic       in_acc;
  logic       adv;
  logic       gen_v;
  res_t       gen;
  logic [15:0] p_dec;
  logic [15:0] a_dec;
  logic        p_in;
  logic        a_in;
  logic [CW-1:0] pos1, pos2, pos3;
  logic [TW-1:0] rc_idx;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign adv       = !out_valid || !out_stall;
  assign kind      = o.kind;
  assign source    = o.source;
  assign fired_ref = o.fired_ref;
  assign slot      = o.slot;
  assign ok        = o.ok;
  assign last      = o_last;

  assign p_in  = (i < WW'(pcount));
  assign a_in  = (i < WW'(acount));
  assign p_dec = p_rem[i[PW-1:0]] - 16'd1;
  assign a_dec = a_cnt[i[AW-1:0]] - 16'd1;
  assign pos1  = cnt[1] - spr[0];
  assign pos2  = cnt[2] - spr[1];
  assign pos3  = cnt[3] - spr[2];
  assign rc_idx = cnt[rate_class][TW-1:0];

  always_comb begin
    gen_v         = 1'b0;
    gen.kind      = KIND_DISPATCH;
    gen.source    = SRC_1MS;
    gen.fired_ref = 8'd0;
    gen.slot      = 3'd0;
    gen.ok        = 1'b1;
    case (state)
      S_P1: begin
        if (i < WW'(cnt[0])) begin
          gen_v         = 1'b1;
          gen.fired_ref = rt[0][i[TW-1:0]];
          gen.slot      = 3'(i);
        end
      end
      S_SP1: begin
        if (spr[0] != '0 && spr[0] <= cnt[1]) begin
          gen_v         = 1'b1;
          gen.source    = SRC_10MS;
          gen.fired_ref = rt[1][pos1[TW-1:0]];
          gen.slot      = 3'(pos1);
        end
      end
      S_SP2: begin
        if (c10 == 4'd0 && spr[1] != '0 && spr[1] <= cnt[2]) begin
          gen_v         = 1'b1;
          gen.source    = SRC_100MS;
          gen.fired_ref = rt[2][pos2[TW-1:0]];
          gen.slot      = 3'(pos2);
        end
      end
      S_SP3: begin
        if (c100 == 7'd99 && spr[2] != '0 && spr[2] <= cnt[3]) begin
          gen_v         = 1'b1;
          gen.source    = SRC_1S;
          gen.fired_ref = rt[3][pos3[TW-1:0]];
          gen.slot      = 3'(pos3);
        end
      end
      S_PER: begin
        if (p_in && p_dec == 16'd0) begin
          gen_v         = 1'b1;
          gen.source    = SRC_PERIODIC;
          gen.fired_ref = p_ref[i[PW-1:0]];
          gen.slot      = 3'(i);
        end
      end
      S_ALM: begin
        if (a_in && a_dec == 16'd0) begin
          gen_v         = 1'b1;
          gen.source    = SRC_ALARM;
          gen.fired_ref = a_ref[i[AW-1:0]];
          gen.slot      = 3'(i);
        end
      end
      default: begin
      end
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < ALARM_MAX; k++) begin : g_alarm
      logic [7:0]  nref;
      logic [15:0] ncnt;
      if (k + 1 < ALARM_MAX) begin : g_mid
        assign nref = a_ref[k + 1];
        assign ncnt = a_cnt[k + 1];
      end else begin : g_end
        assign nref = a_ref[k];
        assign ncnt = a_cnt[k];
      end
      always_comb begin
        a_ctl[k].load = in_acc && action == ACT_ADD_ALARM &&
                        acount < ACW'(ALARM_MAX) && acount == ACW'(k);
        a_ctl[k].take = state == S_ALM && adv && a_in && a_dec == 16'd0 &&
                        WW'(k) >= i;
        a_ctl[k].dec  = state == S_ALM && adv && a_in && a_dec != 16'd0 &&
                        WW'(k) == i;
      end
      ttds_alarm_cell u_cell (
        .clk      (clk),
        .ctl      (a_ctl[k]),
        .load_ref (task_ref),
        .load_cnt (duration),
        .next_ref (nref),
        .next_cnt (ncnt),
        .ref_q    (a_ref[k]),
        .cnt_q    (a_cnt[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_ADD_RATE && cnt[rate_class] < CW'(TASKS_PER_CLASS)) begin
      rt[rate_class][rc_idx] <= task_ref;
    end
    if (in_acc && action == ACT_REM_RATE && {1'b0, slot_index} < 4'(cnt[rate_class])) begin
      for (int j = 0; j + 1 < TASKS_PER_CLASS; j++) begin
        if (j >= int'(slot_index)) begin
          rt[rate_class][j] <= rt[rate_class][j + 1];
        end
      end
    end
    if (in_acc && action == ACT_ADD_PER && pcount < PCW'(PERIODIC_MAX)) begin
      p_ref[pcount[PW-1:0]] <= task_ref;
      p_rel[pcount[PW-1:0]] <= duration;
      p_rem[pcount[PW-1:0]] <= duration;
    end
    if (state == S_PER && adv && p_in) begin
      p_rem[i[PW-1:0]] <= (p_dec == 16'd0) ? p_rel[i[PW-1:0]] : p_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      h_v       <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) cnt[c] <= '0;
      for (int c = 0; c < 3; c++) spr[c] <= '0;
      tc        <= 10'd0;
      c10       <= 4'd0;
      c100      <= 7'd0;
      pcount    <= '0;
      acount    <= '0;
      i         <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (gen_v && adv) begin
        if (h_v) begin
          o         <= h;
          o_last    <= 1'b0;
          out_valid <= 1'b1;
        end
        h   <= gen;
        h_v <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            h.kind <= KIND_REPLY;
            case (action)
              ACT_TICK: begin
                i     <= '0;
                state <= S_P1;
              end
              ACT_ADD_RATE: begin
                h.source <= 3'(rate_class);
                h_v      <= 1'b1;
                state    <= S_FLUSH;
                if (cnt[rate_class] < CW'(TASKS_PER_CLASS)) begin
                  h.fired_ref     <= task_ref;
                  h.slot          <= 3'(cnt[rate_class]);
                  h.ok            <= 1'b1;
                  cnt[rate_class] <= cnt[rate_class] + 1'b1;
                end else begin
                  h.fired_ref <= 8'd0;
                  h.slot      <= 3'd0;
                  h.ok        <= 1'b0;
                end
              end
              ACT_REM_RATE: begin
                h.source <= 3'(rate_class);
                h.slot   <= slot_index;
                h_v      <= 1'b1;
                state    <= S_FLUSH;
                if ({1'b0, slot_index} < 4'(cnt[rate_class])) begin
                  h.fired_ref     <= rt[rate_class][slot_index[TW-1:0]];
                  h.ok            <= 1'b1;
                  cnt[rate_class] <= cnt[rate_class] - 1'b1;
                end else begin
                  h.fired_ref <= 8'd0;
                  h.ok        <= 1'b0;
                end
              end
              ACT_ADD_PER: begin
                h.source <= SRC_PERIODIC;
                h_v      <= 1'b1;
                state    <= S_FLUSH;
                if (pcount < PCW'(PERIODIC_MAX)) begin
                  h.fired_ref <= task_ref;
                  h.slot      <= 3'(pcount);
                  h.ok        <= 1'b1;
                  pcount      <= pcount + 1'b1;
                end else begin
                  h.fired_ref <= 8'd0;
                  h.slot      <= 3'd0;
                  h.ok        <= 1'b0;
                end
              end
              ACT_CLR_PER: begin
                h.source    <= SRC_PERIODIC;
                h.fired_ref <= 8'd0;
                h.slot      <= 3'd0;
                h.ok        <= 1'b1;
                h_v         <= 1'b1;
                pcount      <= '0;
                state       <= S_FLUSH;
              end
              ACT_ADD_ALARM: begin
                h.source <= SRC_ALARM;
                h_v      <= 1'b1;
                state    <= S_FLUSH;
                if (acount < ACW'(ALARM_MAX)) begin
                  h.fired_ref <= task_ref;
                  h.slot      <= 3'(acount);
                  h.ok        <= 1'b1;
                  acount      <= acount + 1'b1;
                end else begin
                  h.fired_ref <= 8'd0;
                  h.slot      <= 3'd0;
                  h.ok        <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_P1: begin
          if (adv) begin
            if (i < WW'(cnt[0])) i <= i + 1'b1;
            else state <= S_SP1;
          end
        end
        S_SP1: begin
          if (adv) begin
            if (spr[0] != '0) spr[0] <= spr[0] - 1'b1;
            if (c10 == 4'd0) spr[0] <= cnt[1];
            state <= S_SP2;
          end
        end
        S_SP2: begin
          if (adv) begin
            if (c10 == 4'd0 && spr[1] != '0) spr[1] <= spr[1] - 1'b1;
            if (c100 == 7'd0) spr[1] <= cnt[2];
            state <= S_SP3;
          end
        end
        S_SP3: begin
          if (adv) begin
            if (c100 == 7'd99 && spr[2] != '0) spr[2] <= spr[2] - 1'b1;
            if (tc == 10'd0 || tc == 10'd1000) begin
              spr[2] <= cnt[3];
              tc     <= 10'd1;
              c10    <= 4'd1;
              c100   <= 7'd1;
            end else begin
              tc   <= tc + 10'd1;
              c10  <= (c10 == 4'd9) ? 4'd0 : c10 + 4'd1;
              c100 <= (c100 == 7'd99) ? 7'd0 : c100 + 7'd1;
            end
            i     <= '0;
            state <= S_PER;
          end
        end
        S_PER: begin
          if (adv) begin
            if (p_in) begin
              i <= i + 1'b1;
            end else begin
              i     <= '0;
              state <= S_ALM;
            end
          end
        end
        S_ALM: begin
          if (adv) begin
            if (a_in) begin
              if (a_dec == 16'd0) acount <= acount - 1'b1;
              else i <= i + 1'b1;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (adv) begin
            if (h_v) begin
              o         <= h;
              o_last    <= 1'b1;
              out_valid <= 1'b1;
              h_v       <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_alarm_bound: assert property (@(posedge clk) disable iff (rst)
    acount <= ACW'(ALARM_MAX)) else $error("alarm count beyond list size");

  a_periodic_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= PCW'(PERIODIC_MAX)) else $error("periodic count beyond list size");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !h_v) else $error("staged word left behind in idle");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tc <= 10'd1000) else $error("tick counter out of range");

endmodule
